// ===== hdl/triangle_vertex_csr_build_top_macros.svh =====
// Assertion shorthands for the incidence table builder.
`ifndef TRIANGLE_VERTEX_CSR_BUILD_TOP_MACROS_SVH
`define TRIANGLE_VERTEX_CSR_BUILD_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TVCB_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tvcb check failed");

// Consequent must hold in the cycle after the antecedent.
`define TVCB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tvcb check failed");

`endif

// ===== hdl/tvcb_pkg.sv =====
package tvcb_pkg;

	localparam int VCOUNT_W   = 11;
	localparam int VERT_W     = 10;
	localparam int IDX_W      = 12;
	localparam int OFFV_W     = 12;
	localparam int FACE_NUM_W = 10;
	localparam int ROLE_W     = 2;
	localparam int STATUS_W   = 3;
	localparam int OP_W       = 3;

	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
	localparam logic [OP_W-1:0] OP_LOAD    = 3'd1;
	localparam logic [OP_W-1:0] OP_BUILD   = 3'd2;
	localparam logic [OP_W-1:0] OP_RD_OFF  = 3'd3;
	localparam logic [OP_W-1:0] OP_RD_ADJ  = 3'd4;

	localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_VERTEX    = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_INDEX     = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_NOT_BUILT = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [VERT_W-1:0] vertex_a;
		logic [VERT_W-1:0] vertex_b;
		logic [VERT_W-1:0] vertex_c;
		logic [IDX_W-1:0]  read_index;
	} cmd_t;

	typedef struct packed {
		logic [OFFV_W-1:0]     offset_value;
		logic [FACE_NUM_W-1:0] face_number;
		logic [ROLE_W-1:0]     corner_role;
		logic [OFFV_W-1:0]     entry_total;
		logic [STATUS_W-1:0]   status;
	} rsp_t;

endpackage

// ===== hdl/triangle_vertex_csr_build_top.sv =====
// Vertex-to-face incidence table builder (CSR by counting sort).
// cmd channel (cmd_valid/cmd_stall/cmd) takes one op per item: clear, load
// triangle, build, read offset, read adjacency. Every item yields exactly one
// rsp item (rsp_valid/rsp_stall/rsp) carrying entry_total and a status code.
// cfg_wr_en/cfg_wr_data write vertex_count; write only while the block is idle.
// Clear, load and rejected ops answer straight from idle; offset and adjacency
// reads go through one memory read first. Build, for the stored triangles, runs
// a zeroing sweep of the offset memory, a count pass per triangle (face read,
// then read-modify-write of one counter per corner), a pipelined prefix sweep,
// and a scatter of entries through the cursor memory.
// One item is in flight at a time; cmd_stall is high while an op is working
// and while a finished result is held by rsp_stall.
// Reset clears the triangle count, vertex_count and the built flag; memory
// contents are not cleared, since build rewrites every entry it later reads.
// A stalled rsp item holds its value until taken.
module triangle_vertex_csr_build_top #(
	parameter int MAX_VERTICES  = 1024,
	parameter int MAX_TRIANGLES = 1024
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [tvcb_pkg::VCOUNT_W-1:0]       cfg_wr_data,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  tvcb_pkg::cmd_t                      cmd,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output tvcb_pkg::rsp_t                      rsp
);

	localparam int VA_W      = $clog2(MAX_VERTICES + 1);
	localparam int VX_W      = $clog2(MAX_VERTICES);
	localparam int TC_W      = $clog2(MAX_TRIANGLES + 1);
	localparam int FACE_W    = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
	localparam int ADJ_DEPTH = 3 * MAX_TRIANGLES;
	localparam int AD_W      = $clog2(ADJ_DEPTH);
	localparam int OFF_W     = $clog2(ADJ_DEPTH + 1);
	localparam int ROLE_W    = tvcb_pkg::ROLE_W;
	localparam int ADJ_W     = FACE_W + ROLE_W;

	typedef struct packed {
		logic [tvcb_pkg::VERT_W-1:0] vertex_a;
		logic [tvcb_pkg::VERT_W-1:0] vertex_b;
		logic [tvcb_pkg::VERT_W-1:0] vertex_c;
	} face_ent_t;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_RD_WAIT  = 10'b0000000010,
		S_ZERO     = 10'b0000000100,
		S_CNT_FACE = 10'b0000001000,
		S_CNT_RD   = 10'b0000010000,
		S_CNT_WR   = 10'b0000100000,
		S_PREFIX   = 10'b0001000000,
		S_SCT_FACE = 10'b0010000000,
		S_SCT_RD   = 10'b0100000000,
		S_SCT_WR   = 10'b1000000000
	} state_t;

	// memories
	face_ent_t        face_mem [MAX_TRIANGLES];
	logic [OFF_W-1:0] off_mem  [MAX_VERTICES + 1];
	logic [OFF_W-1:0] cur_mem  [MAX_VERTICES];
	logic [ADJ_W-1:0] adj_mem  [ADJ_DEPTH];

	face_ent_t        face_rd_q;
	logic [OFF_W-1:0] off_rd_q;
	logic [OFF_W-1:0] cur_rd_q;
	logic [ADJ_W-1:0] adj_rd_q;

	logic             face_re, face_we;
	face_ent_t        face_wd;
	logic             off_re, off_we;
	logic [VA_W-1:0]  off_ra, off_wa;
	logic [OFF_W-1:0] off_wd;
	logic             cur_re, cur_we;
	logic [VX_W-1:0]  cur_ra, cur_wa;
	logic [OFF_W-1:0] cur_wd;
	logic             adj_re, adj_we;
	logic [AD_W-1:0]  adj_ra, adj_wa;
	logic [ADJ_W-1:0] adj_wd;

	// control
	state_t                         state_q, state_d;
	logic [tvcb_pkg::VCOUNT_W-1:0]  vcount_q;
	logic [TC_W-1:0]                tot_q;
	logic                           built_q;
	logic [TC_W-1:0]                f_q;
	logic [1:0]                     k_q;
	logic [VA_W-1:0]                p_q;
	logic                           p_issue_q;
	logic [VA_W-1:0]                pfx_addr_s1;
	logic                           pfx_valid_s1;
	logic [OFF_W-1:0]               acc_q;
	logic                           rd_adj_q;

	tvcb_pkg::rsp_t                 rsp_q, rsp_d;
	logic                           rsp_valid_q, rsp_load;

	logic                           cmd_fire;
	logic [VA_W-1:0]                lim;
	logic [OFF_W-1:0]               ent_cnt;
	logic [OFF_W-1:0]               acc_sum;
	logic [tvcb_pkg::VERT_W-1:0]    vert;
	logic [VA_W-1:0]                vert_a1;
	logic                           last_face, last_vtx;
	logic                           bad_vertex, store_full, load_ok, build_done;

	assign cmd_stall = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign lim = (32'(vcount_q) > 32'(MAX_VERTICES)) ? VA_W'(MAX_VERTICES)
		: VA_W'(vcount_q);
	assign ent_cnt    = (OFF_W'(tot_q) << 1) + OFF_W'(tot_q);
	assign acc_sum    = acc_q + off_rd_q;
	assign last_face  = (TC_W'(f_q + TC_W'(1)) == tot_q);
	assign last_vtx   = (p_q == VA_W'(MAX_VERTICES));
	assign store_full = (tot_q == TC_W'(MAX_TRIANGLES));
	assign bad_vertex = (32'(cmd.vertex_a) >= 32'(lim)) || (32'(cmd.vertex_b) >= 32'(lim))
		|| (32'(cmd.vertex_c) >= 32'(lim));
	assign load_ok    = cmd_fire && (cmd.op == tvcb_pkg::OP_LOAD) && !bad_vertex && !store_full;

	always_comb begin
		unique case (k_q)
			2'd0:    vert = face_rd_q.vertex_a;
			2'd1:    vert = face_rd_q.vertex_b;
			default: vert = face_rd_q.vertex_c;
		endcase
	end
	// count for vertex v lives one slot up, so the prefix lands as exclusive offsets
	assign vert_a1 = VA_W'(vert) + VA_W'(1);

	assign face_wd = '{vertex_a: cmd.vertex_a, vertex_b: cmd.vertex_b, vertex_c: cmd.vertex_c};

	always_comb begin
		state_d    = state_q;
		face_re    = 1'b0;
		face_we    = load_ok;
		off_re     = 1'b0;
		off_ra     = '0;
		off_we     = 1'b0;
		off_wa     = '0;
		off_wd     = '0;
		cur_re     = 1'b0;
		cur_ra     = VX_W'(vert);
		cur_we     = 1'b0;
		cur_wa     = VX_W'(vert);
		cur_wd     = '0;
		adj_re     = 1'b0;
		adj_ra     = AD_W'(cmd.read_index);
		adj_we     = 1'b0;
		adj_wa     = AD_W'(cur_rd_q);
		adj_wd     = {f_q[FACE_W-1:0], k_q};
		rsp_load   = 1'b0;
		build_done = 1'b0;
		rsp_d              = '0;
		rsp_d.entry_total  = 12'(ent_cnt);
		rsp_d.status       = tvcb_pkg::STAT_OK;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					unique case (cmd.op)
						tvcb_pkg::OP_CLEAR: begin
							rsp_load          = 1'b1;
							rsp_d.entry_total = '0;
						end
						tvcb_pkg::OP_LOAD: begin
							rsp_load = 1'b1;
							if (bad_vertex) begin
								rsp_d.status = tvcb_pkg::STAT_VERTEX;
							end else if (store_full) begin
								rsp_d.status = tvcb_pkg::STAT_FULL;
							end else begin
								rsp_d.entry_total = 12'(ent_cnt + OFF_W'(3));
							end
						end
						tvcb_pkg::OP_BUILD: begin
							state_d = S_ZERO;
						end
						tvcb_pkg::OP_RD_OFF: begin
							if (!built_q) begin
								rsp_load     = 1'b1;
								rsp_d.status = tvcb_pkg::STAT_NOT_BUILT;
							end else if (32'(cmd.read_index) > 32'(lim)) begin
								rsp_load     = 1'b1;
								rsp_d.status = tvcb_pkg::STAT_INDEX;
							end else begin
								off_re  = 1'b1;
								off_ra  = VA_W'(cmd.read_index);
								state_d = S_RD_WAIT;
							end
						end
						tvcb_pkg::OP_RD_ADJ: begin
							if (!built_q) begin
								rsp_load     = 1'b1;
								rsp_d.status = tvcb_pkg::STAT_NOT_BUILT;
							end else if (32'(cmd.read_index) >= 32'(ent_cnt)) begin
								rsp_load     = 1'b1;
								rsp_d.status = tvcb_pkg::STAT_INDEX;
							end else begin
								adj_re  = 1'b1;
								state_d = S_RD_WAIT;
							end
						end
						default: begin
							rsp_load     = 1'b1;
							rsp_d.status = tvcb_pkg::STAT_INDEX;
						end
					endcase
				end
			end
			S_RD_WAIT: begin
				rsp_load = 1'b1;
				if (rd_adj_q) begin
					rsp_d.face_number = 10'(adj_rd_q[ADJ_W-1:ROLE_W]);
					rsp_d.corner_role = adj_rd_q[ROLE_W-1:0];
				end else begin
					rsp_d.offset_value = 12'(off_rd_q);
				end
				state_d = S_IDLE;
			end
			S_ZERO: begin
				off_we = 1'b1;
				off_wa = p_q;
				if (last_vtx) begin
					state_d = (tot_q == '0) ? S_PREFIX : S_CNT_FACE;
				end
			end
			S_CNT_FACE: begin
				face_re = 1'b1;
				state_d = S_CNT_RD;
			end
			S_CNT_RD: begin
				off_re  = 1'b1;
				off_ra  = vert_a1;
				state_d = S_CNT_WR;
			end
			S_CNT_WR: begin
				// next corner reads only after this write lands, so no forwarding
				off_we = 1'b1;
				off_wa = vert_a1;
				off_wd = off_rd_q + OFF_W'(1);
				if (k_q == 2'd2) begin
					state_d = last_face ? S_PREFIX : S_CNT_FACE;
				end else begin
					state_d = S_CNT_RD;
				end
			end
			S_PREFIX: begin
				// read slot p while slot p-1 is written back
				off_re = p_issue_q;
				off_ra = p_q;
				if (pfx_valid_s1) begin
					off_we = 1'b1;
					off_wa = pfx_addr_s1;
					off_wd = acc_sum;
					cur_we = (pfx_addr_s1 != VA_W'(MAX_VERTICES));
					cur_wa = VX_W'(pfx_addr_s1);
					cur_wd = acc_sum;
					if (!p_issue_q) begin
						if (tot_q == '0) begin
							rsp_load   = 1'b1;
							build_done = 1'b1;
							state_d    = S_IDLE;
						end else begin
							state_d = S_SCT_FACE;
						end
					end
				end
			end
			S_SCT_FACE: begin
				face_re = 1'b1;
				state_d = S_SCT_RD;
			end
			S_SCT_RD: begin
				cur_re  = 1'b1;
				state_d = S_SCT_WR;
			end
			S_SCT_WR: begin
				adj_we = 1'b1;
				cur_we = 1'b1;
				cur_wd = cur_rd_q + OFF_W'(1);
				if (k_q == 2'd2) begin
					if (last_face) begin
						rsp_load   = 1'b1;
						build_done = 1'b1;
						state_d    = S_IDLE;
					end else begin
						state_d = S_SCT_FACE;
					end
				end else begin
					state_d = S_SCT_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (face_we) begin
			face_mem[tot_q[FACE_W-1:0]] <= face_wd;
		end
		if (face_re) begin
			face_rd_q <= face_mem[f_q[FACE_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (off_we) begin
			off_mem[off_wa] <= off_wd;
		end
		if (off_re) begin
			off_rd_q <= off_mem[off_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
		if (cur_re) begin
			cur_rd_q <= cur_mem[cur_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (adj_we) begin
			adj_mem[adj_wa] <= adj_wd;
		end
		if (adj_re) begin
			adj_rd_q <= adj_mem[adj_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		if (state_q == S_PREFIX && p_issue_q) begin
			pfx_addr_s1 <= p_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			vcount_q     <= '0;
			tot_q        <= '0;
			built_q      <= 1'b0;
			f_q          <= '0;
			k_q          <= '0;
			p_q          <= '0;
			p_issue_q    <= 1'b0;
			pfx_valid_s1 <= 1'b0;
			acc_q        <= '0;
			rd_adj_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			if (cmd_fire && cmd.op == tvcb_pkg::OP_CLEAR) begin
				tot_q <= '0;
			end
			if (load_ok) begin
				tot_q <= tot_q + TC_W'(1);
			end
			if (build_done) begin
				built_q <= 1'b1;
			end else if (cfg_wr_en || load_ok
				|| (cmd_fire && cmd.op == tvcb_pkg::OP_CLEAR)) begin
				built_q <= 1'b0;
			end
			if (cmd_fire) begin
				rd_adj_q <= (cmd.op == tvcb_pkg::OP_RD_ADJ);
			end

			unique case (state_q)
				S_IDLE: begin
					p_q <= '0;
				end
				S_ZERO: begin
					if (last_vtx) begin
						p_q          <= '0;
						p_issue_q    <= 1'b1;
						pfx_valid_s1 <= 1'b0;
						acc_q        <= '0;
						f_q          <= '0;
					end else begin
						p_q <= p_q + VA_W'(1);
					end
				end
				S_CNT_FACE, S_SCT_FACE: begin
					k_q <= '0;
				end
				S_CNT_WR, S_SCT_WR: begin
					if (k_q == 2'd2) begin
						f_q <= f_q + TC_W'(1);
					end else begin
						k_q <= k_q + 2'd1;
					end
				end
				S_PREFIX: begin
					pfx_valid_s1 <= p_issue_q;
					if (p_issue_q) begin
						if (last_vtx) begin
							p_issue_q <= 1'b0;
						end else begin
							p_q <= p_q + VA_W'(1);
						end
					end
					if (pfx_valid_s1) begin
						acc_q <= acc_sum;
						if (!p_issue_q) begin
							f_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ===== hdl/tvcb_checker.sv =====
`include "triangle_vertex_csr_build_top_macros.svh"

module tvcb_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input tvcb_pkg::cmd_t cmd,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input tvcb_pkg::rsp_t rsp
);

	`TVCB_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

	// a held result blocks new items, otherwise the output register would be overrun
	`TVCB_ASSERT_SAME(a_cmd_blocked, clk, arst_n, rsp_valid && rsp_stall, cmd_stall)

	`TVCB_ASSERT_SAME(a_err_zero, clk, arst_n, rsp_valid && (rsp.status != tvcb_pkg::STAT_OK), (rsp.offset_value == '0) && (rsp.face_number == '0) && (rsp.corner_role == '0))

	`TVCB_ASSERT_NEXT(a_clear_rsp, clk, arst_n, cmd_valid && !cmd_stall && (cmd.op == tvcb_pkg::OP_CLEAR), rsp_valid && (rsp.entry_total == '0) && (rsp.status == tvcb_pkg::STAT_OK))

endmodule

bind triangle_vertex_csr_build_top tvcb_checker u_tvcb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd_valid),
	.cmd_stall (cmd_stall),
	.cmd       (cmd),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

// ===== tb/triangle_vertex_csr_build_top_tb.sv =====
module triangle_vertex_csr_build_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_VERTS    = 1024;
	localparam int MAX_TRIS     = 1024;
	localparam int OFFSET_SLOTS = MAX_VERTS + 1;
	localparam int ADJ_SLOTS    = 3 * MAX_TRIS;
	localparam int IDX_MAX      = (1 << tvcb_pkg::IDX_W) - 1;
	localparam int VERT_MAX     = (1 << tvcb_pkg::VERT_W) - 1;
	localparam logic [tvcb_pkg::OP_W-1:0] OP_ILLEGAL_MIN = 3'd5;
	localparam logic [tvcb_pkg::OP_W-1:0] OP_ILLEGAL_MAX = 3'd7;
	localparam int MAX_PRINTED  = 100;

	localparam int PHASE_VCOUNT [8] = '{3, 1024, 2047, 1, 0, 40, 1024, 600};
	localparam int SEND_IDLE [4]    = '{0, 59, 0, 7};
	localparam int RECV_STALL [4]   = '{0, 0, 59, 7};
	localparam int PHASE_ITEMS      = 88;

	class csr_table_checker;
		logic [tvcb_pkg::VCOUNT_W-1:0]   vcount;
		logic [tvcb_pkg::VERT_W-1:0]     tri_corner [MAX_TRIS][3];
		int                              tri_total;
		logic [tvcb_pkg::OFFV_W-1:0]     offset_tab [OFFSET_SLOTS];
		logic [tvcb_pkg::OFFV_W-1:0]     cursor_tab [MAX_VERTS];
		logic [tvcb_pkg::FACE_NUM_W-1:0] adj_face [ADJ_SLOTS];
		logic [tvcb_pkg::ROLE_W-1:0]     adj_role [ADJ_SLOTS];
		bit                              built;
		tvcb_pkg::rsp_t                  replies_due [$];
		int                              errors;

		function new();
			vcount = '0;
			errors = 0;
			wipe();
		endfunction

		function int live_vertices();
			return (vcount > MAX_VERTS) ? MAX_VERTS : int'(vcount);
		endfunction

		function void set_vcount(logic [tvcb_pkg::VCOUNT_W-1:0] v);
			vcount = v;
			built = 1'b0;
		endfunction

		function void wipe();
			tri_total = 0;
			built = 1'b0;
			foreach (offset_tab[i]) offset_tab[i] = '0;
			foreach (cursor_tab[i]) cursor_tab[i] = '0;
		endfunction

		// counting sort: tally corners, exclusive prefix, then scatter in load order
		function void rebuild_table();
			int vx;
			int slot;
			foreach (offset_tab[i]) offset_tab[i] = '0;
			foreach (cursor_tab[i]) cursor_tab[i] = '0;
			for (int f = 0; f < tri_total; f++) begin
				for (int k = 0; k < 3; k++) begin
					vx = tri_corner[f][k];
					offset_tab[vx + 1] = offset_tab[vx + 1] + 1'b1;
				end
			end
			for (int v = 0; v < MAX_VERTS; v++)
				offset_tab[v + 1] = offset_tab[v + 1] + offset_tab[v];
			for (int f = 0; f < tri_total; f++) begin
				for (int k = 0; k < 3; k++) begin
					vx = tri_corner[f][k];
					slot = offset_tab[vx] + cursor_tab[vx];
					cursor_tab[vx] = cursor_tab[vx] + 1'b1;
					if (slot < ADJ_SLOTS) begin
						adj_face[slot] = tvcb_pkg::FACE_NUM_W'(f);
						adj_role[slot] = tvcb_pkg::ROLE_W'(k);
					end
				end
			end
			built = 1'b1;
		endfunction

		function void take_cmd(tvcb_pkg::cmd_t c);
			tvcb_pkg::rsp_t r;
			int lim;
			r = '0;
			lim = live_vertices();
			case (c.op)
				tvcb_pkg::OP_CLEAR: wipe();
				tvcb_pkg::OP_LOAD: begin
					if (c.vertex_a >= lim || c.vertex_b >= lim || c.vertex_c >= lim) begin
						r.status = tvcb_pkg::STAT_VERTEX;
					end else if (tri_total >= MAX_TRIS) begin
						r.status = tvcb_pkg::STAT_FULL;
					end else begin
						tri_corner[tri_total][0] = c.vertex_a;
						tri_corner[tri_total][1] = c.vertex_b;
						tri_corner[tri_total][2] = c.vertex_c;
						tri_total++;
						built = 1'b0;
					end
				end
				tvcb_pkg::OP_BUILD: rebuild_table();
				tvcb_pkg::OP_RD_OFF: begin
					if (!built)
						r.status = tvcb_pkg::STAT_NOT_BUILT;
					else if (c.read_index > lim)
						r.status = tvcb_pkg::STAT_INDEX;
					else
						r.offset_value = offset_tab[c.read_index];
				end
				tvcb_pkg::OP_RD_ADJ: begin
					if (!built) begin
						r.status = tvcb_pkg::STAT_NOT_BUILT;
					end else if (c.read_index >= 3 * tri_total) begin
						r.status = tvcb_pkg::STAT_INDEX;
					end else begin
						r.face_number = adj_face[c.read_index];
						r.corner_role = adj_role[c.read_index];
					end
				end
				default: r.status = tvcb_pkg::STAT_INDEX;
			endcase
			r.entry_total = tvcb_pkg::OFFV_W'(3 * tri_total);
			replies_due = {replies_due, r};
		endfunction

		task flag_mismatch(string what, logic [15:0] got_v, logic [15:0] want_v);
			if (errors < MAX_PRINTED)
				$display("%0t mismatch %s: got %0d, want %0d", $time, what, got_v, want_v);
			errors++;
		endtask

		task check_reply(tvcb_pkg::rsp_t got);
			tvcb_pkg::rsp_t want;
			if (replies_due.size() == 0) begin
				flag_mismatch("item with nothing outstanding, status", got.status, '0);
				return;
			end
			want = replies_due.pop_front();
			if (got.offset_value !== want.offset_value)
				flag_mismatch("offset_value", got.offset_value, want.offset_value);
			if (got.face_number !== want.face_number)
				flag_mismatch("face_number", got.face_number, want.face_number);
			if (got.corner_role !== want.corner_role)
				flag_mismatch("corner_role", got.corner_role, want.corner_role);
			if (got.entry_total !== want.entry_total)
				flag_mismatch("entry_total", got.entry_total, want.entry_total);
			if (got.status !== want.status)
				flag_mismatch("status", got.status, want.status);
		endtask
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [tvcb_pkg::VCOUNT_W-1:0] cfg_wr_data;
	logic                          cmd_valid;
	logic                          cmd_stall;
	tvcb_pkg::cmd_t                cmd;
	logic                          rsp_valid;
	logic                          rsp_stall;
	tvcb_pkg::rsp_t                rsp;

	csr_table_checker chk;
	int send_idle_pct;
	int recv_stall_pct;
	int long_hold_cycles;
	int items_sent;

	triangle_vertex_csr_build_top #(
		.MAX_VERTICES (MAX_VERTS),
		.MAX_TRIANGLES(MAX_TRIS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#20_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side: random stalls, plus a long hold-off counted down here
	initial begin
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
				chk.check_reply(rsp);
			if (long_hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				long_hold_cycles--;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	task automatic send_cmd(tvcb_pkg::cmd_t c);
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		chk.take_cmd(c);
		items_sent++;
	endtask

	// junk goes into the fields an op ignores
	task automatic issue_op(logic [tvcb_pkg::OP_W-1:0] op, int idx);
		tvcb_pkg::cmd_t c;
		c.op = op;
		c.vertex_a = tvcb_pkg::VERT_W'($urandom);
		c.vertex_b = tvcb_pkg::VERT_W'($urandom);
		c.vertex_c = tvcb_pkg::VERT_W'($urandom);
		c.read_index = tvcb_pkg::IDX_W'(idx);
		send_cmd(c);
	endtask

	task automatic issue_load(int a, int b, int vc);
		tvcb_pkg::cmd_t c;
		c.op = tvcb_pkg::OP_LOAD;
		c.vertex_a = tvcb_pkg::VERT_W'(a);
		c.vertex_b = tvcb_pkg::VERT_W'(b);
		c.vertex_c = tvcb_pkg::VERT_W'(vc);
		c.read_index = tvcb_pkg::IDX_W'($urandom);
		send_cmd(c);
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		while (chk.replies_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_vcount(int v);
		wait_idle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= tvcb_pkg::VCOUNT_W'(v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		chk.set_vcount(tvcb_pkg::VCOUNT_W'(v));
	endtask

	// mix of full range, a small shared cluster and the top of the range
	function automatic int pick_vertex(int lim);
		int span;
		span = (lim < 8) ? lim - 1 : 7;
		case ($urandom_range(3))
			0, 1: return $urandom_range(lim - 1);
			2: return $urandom_range(span);
			default: return lim - 1 - $urandom_range(span);
		endcase
	endfunction

	task automatic send_noise(int lim);
		int bad_v;
		int total;
		total = chk.tri_total;
		case ($urandom_range(4))
			0: begin
				if (lim <= VERT_MAX) begin
					bad_v = $urandom_range(lim, VERT_MAX);
					case ($urandom_range(2))
						0: issue_load(bad_v, $urandom, $urandom);
						1: issue_load($urandom_range(lim > 0 ? lim - 1 : 0), bad_v, $urandom);
						default: issue_load($urandom, $urandom, bad_v);
					endcase
				end else begin
					issue_op(tvcb_pkg::OP_W'($urandom_range(OP_ILLEGAL_MIN, OP_ILLEGAL_MAX)),
						$urandom);
				end
			end
			1: issue_op(tvcb_pkg::OP_W'($urandom_range(OP_ILLEGAL_MIN, OP_ILLEGAL_MAX)),
				$urandom);
			2: issue_op(tvcb_pkg::OP_RD_OFF, $urandom_range(lim + 1, IDX_MAX));
			3: issue_op(tvcb_pkg::OP_RD_ADJ, $urandom_range(3 * total, IDX_MAX));
			default: begin
				if ($urandom_range(1))
					issue_load($urandom, $urandom, $urandom);
				else
					issue_op(tvcb_pkg::OP_W'($urandom), $urandom);
			end
		endcase
	endtask

	// loads, a build, then reads of the fresh table, with noise mixed in
	task automatic run_batch();
		int lim;
		int total;
		lim = chk.live_vertices();
		if ($urandom_range(3) == 0)
			issue_op(tvcb_pkg::OP_CLEAR, $urandom);
		repeat ($urandom_range(1, 10)) begin
			if (lim > 0 && $urandom_range(9) != 0)
				issue_load(pick_vertex(lim), pick_vertex(lim), pick_vertex(lim));
			else
				send_noise(lim);
		end
		issue_op(tvcb_pkg::OP_BUILD, $urandom);
		repeat ($urandom_range(2, 10)) begin
			total = chk.tri_total;
			case ($urandom_range(9))
				0: send_noise(lim);
				1, 2, 3: issue_op(tvcb_pkg::OP_RD_OFF, $urandom_range(lim));
				default: begin
					if (total > 0)
						issue_op(tvcb_pkg::OP_RD_ADJ, $urandom_range(3 * total - 1));
					else
						issue_op(tvcb_pkg::OP_RD_ADJ, $urandom_range(IDX_MAX));
				end
			endcase
		end
	endtask

	task automatic run_directed();
		// vertex count still zero from reset
		issue_op(tvcb_pkg::OP_RD_OFF, 0);
		issue_op(tvcb_pkg::OP_RD_ADJ, 0);
		issue_load(0, 0, 0);
		for (int op = OP_ILLEGAL_MIN; op <= OP_ILLEGAL_MAX; op++)
			issue_op(tvcb_pkg::OP_W'(op), IDX_MAX);
		issue_op(tvcb_pkg::OP_BUILD, 0);
		issue_op(tvcb_pkg::OP_RD_OFF, 0);
		issue_op(tvcb_pkg::OP_RD_OFF, IDX_MAX);
		issue_op(tvcb_pkg::OP_RD_ADJ, 0);

		write_vcount(MAX_VERTS);
		issue_load(0, 0, 0);
		issue_load(VERT_MAX, VERT_MAX, VERT_MAX);
		issue_load(VERT_MAX, 0, 512);
		issue_op(tvcb_pkg::OP_RD_OFF, 0);
		issue_op(tvcb_pkg::OP_BUILD, 0);
		issue_op(tvcb_pkg::OP_RD_OFF, 1);
		issue_op(tvcb_pkg::OP_RD_OFF, VERT_MAX);
		issue_op(tvcb_pkg::OP_RD_OFF, MAX_VERTS);
		issue_op(tvcb_pkg::OP_RD_OFF, MAX_VERTS + 1);
		issue_op(tvcb_pkg::OP_RD_ADJ, 0);
		issue_op(tvcb_pkg::OP_RD_ADJ, 8);
		issue_op(tvcb_pkg::OP_RD_ADJ, 9);
		// load after build drops the built table
		issue_load(1, 2, 3);
		issue_op(tvcb_pkg::OP_RD_ADJ, 0);
		issue_op(tvcb_pkg::OP_CLEAR, 0);
		issue_op(tvcb_pkg::OP_BUILD, 0);
		issue_op(tvcb_pkg::OP_RD_OFF, MAX_VERTS);
	endtask

	task automatic fill_store();
		write_vcount(MAX_VERTS);
		issue_op(tvcb_pkg::OP_CLEAR, 0);
		repeat (MAX_TRIS)
			issue_load(pick_vertex(MAX_VERTS), pick_vertex(MAX_VERTS), pick_vertex(MAX_VERTS));
		issue_load(7, 8, 9);
		// lowered count: stored triangles keep their slots
		write_vcount(512);
		issue_load(1000, 1, 2);
		issue_load(1, 2, 3);
		issue_op(tvcb_pkg::OP_BUILD, 0);
		issue_op(tvcb_pkg::OP_RD_OFF, 512);
		issue_op(tvcb_pkg::OP_RD_OFF, 513);
		repeat (6)
			issue_op(tvcb_pkg::OP_RD_ADJ, $urandom_range(ADJ_SLOTS - 1));
		issue_op(tvcb_pkg::OP_RD_ADJ, ADJ_SLOTS - 1);
		issue_op(tvcb_pkg::OP_RD_ADJ, ADJ_SLOTS);
		issue_op(tvcb_pkg::OP_CLEAR, 0);
	endtask

	initial begin
		int target;
		int vc;
		chk = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		rsp_stall = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		long_hold_cycles = 0;
		items_sent = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		fill_store();

		for (int p = 0; p < 8; p++) begin
			vc = (p == 7) ? $urandom_range(2, MAX_VERTS - 1) : PHASE_VCOUNT[p];
			write_vcount(vc);
			send_idle_pct = SEND_IDLE[p % 4];
			recv_stall_pct = RECV_STALL[p % 4];
			// long hold-off so the single item in flight backs up the command side
			if (p == 0 || p == 4)
				long_hold_cycles = 300;
			if (p == 1 || p == 5)
				issue_op(tvcb_pkg::OP_CLEAR, $urandom);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target)
				run_batch();
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (chk.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/tvcb_pkg.sv
hdl/triangle_vertex_csr_build_top.sv
hdl/tvcb_checker.sv
tb/triangle_vertex_csr_build_top_tb.sv
